FILE: sv/assert_macros.svh
// Assertion macros for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define BGEL_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

`define BGEL_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`else

`define BGEL_ASSERT_IMP(lbl, clk, rst_n, ante, cons)

`define BGEL_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

FILE: sv/bgel_pkg.sv
`timescale 1ns / 1ps

package bgel_pkg;

    localparam int MV_W      = 14;
    localparam int PCT_W     = 7;
    localparam int CNT_W     = 4;
    localparam int MS_W      = 17;
    localparam int SEG_W     = 4;
    localparam int NUM_W     = 13;
    localparam int DEN_W     = 10;
    localparam int QUOT_W    = 4;
    localparam int DIV_STEPS = 4;
    localparam int STEP_W    = 2;

    localparam logic [1:0] REQ_SAMPLE  = 2'd0;
    localparam logic [1:0] REQ_PRESS   = 2'd1;
    localparam logic [1:0] REQ_RELEASE = 2'd2;
    localparam logic [1:0] REQ_TICK    = 2'd3;

    localparam logic [1:0] CFG_LOW_PCT    = 2'd0;
    localparam logic [1:0] CFG_LOW_LIMIT  = 2'd1;
    localparam logic [1:0] CFG_LONG_PRESS = 2'd2;
    localparam logic [1:0] CFG_OPEN_PER   = 2'd3;

    localparam logic [PCT_W-1:0] PCT_MAX     = 7'd100;
    localparam logic [MS_W-1:0]  ELAPSED_MAX = 17'h1FFFF;

    localparam logic [MV_W-1:0] MV_TABLE [11] = '{
        14'd3000, 14'd3650, 14'd3700, 14'd3740, 14'd3760, 14'd3795,
        14'd3840, 14'd3910, 14'd3980, 14'd4070, 14'd4200
    };

    typedef struct packed {
        logic [1:0]      req_type;
        logic [MV_W-1:0] battery_mv;
    } in_beat_t;

    typedef struct packed {
        logic [PCT_W-1:0] battery_percent;
        logic [CNT_W-1:0] low_count;
        logic             emergency;
        logic             open_pulse;
    } out_beat_t;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [QUOT_W-1:0] quot;
    } div_rsp_t;

    function automatic logic [DEN_W-1:0] seg_span(input logic [SEG_W-1:0] seg);
        logic [MV_W-1:0] diff;
        diff = MV_TABLE[seg] - MV_TABLE[seg - 4'd1];
        return diff[DEN_W-1:0];
    endfunction

endpackage

FILE: sv/bgel_div.sv
`timescale 1ns / 1ps

module bgel_div
    import bgel_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic              run_reg,  run_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [NUM_W-1:0]  rem_reg,  rem_next;
    logic [NUM_W-1:0]  dsh_reg,  dsh_next;
    logic [QUOT_W-1:0] quot_reg, quot_next;
    logic              fits;

    assign fits = (rem_reg >= dsh_reg);

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        quot_next = quot_reg;
        if (req.start)
        begin
            run_next  = 1'b1;
            step_next = STEP_W'(DIV_STEPS - 1);
            rem_next  = req.num;
            dsh_next  = {req.den, {(QUOT_W-1){1'b0}}};
            quot_next = '0;
        end
        else if (run_reg)
        begin
            if (fits)
            begin
                rem_next = rem_reg - dsh_reg;
            end
            quot_next = {quot_reg[QUOT_W-2:0], fits};
            dsh_next  = dsh_reg >> 1;
            step_next = step_reg - 1'b1;
            if (step_reg == '0)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        dsh_reg  <= dsh_next;
        quot_reg <= quot_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;

endmodule

FILE: sv/battery_gauge_emergency_latch.sv
`timescale 1ns / 1ps
// Channel  | Signals                              | Beat
// ---------+--------------------------------------+------------------------------
// sample   | sample_valid, sample_stall, sample_data | in_beat_t, one per item
// result   | result_valid, result_stall, result_data | out_beat_t, one per item
// cfg      | cfg_valid, cfg_ready, cfg_index, cfg_data | register write
//
// Button and tick beats pass through the setup and finish states; battery samples
// inside the table also wait in the divide state for the 4-step restoring divider.
// Samples below or above the table skip the divider.
// rst_n clears configuration to its defaults and all gauge and latch state.
// The result register holds a beat while result_stall is high; a new sample
// beat is taken meanwhile, and its result waits for the register to free up.

`include "assert_macros.svh"

module battery_gauge_emergency_latch
    import bgel_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            sample_valid,
    output logic            sample_stall,
    input  in_beat_t        sample_data,
    output logic            result_valid,
    input  logic            result_stall,
    output out_beat_t       result_data,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic [1:0]      cfg_index,
    input  logic [MS_W-1:0] cfg_data
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SETUP  = 4'b0010,
        ST_DIV    = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [PCT_W-1:0] thr_reg,    thr_next;
    logic [CNT_W-1:0] limit_reg,  limit_next;
    logic [MS_W-1:0]  long_reg,   long_next;
    logic [MS_W-1:0]  period_reg, period_next;

    logic [1:0]       req_reg,    req_next;
    logic [MV_W-1:0]  mv_reg,     mv_next;
    logic [SEG_W-1:0] seg_reg,    seg_next;
    logic [PCT_W-1:0] pct_reg,    pct_next;

    logic [PCT_W-1:0] last_reg,   last_next;
    logic [CNT_W-1:0] low_reg,    low_next;
    logic             emerg_reg,  emerg_next;
    logic             held_reg,   held_next;
    logic             done_reg,   done_next;
    logic [MS_W-1:0]  hold_reg,   hold_next;
    logic [MS_W-1:0]  open_reg,   open_next;

    logic             res_valid_reg, res_valid_next;
    out_beat_t        res_data_reg,  res_data_next;

    div_req_t         div_req;
    div_rsp_t         div_rsp;

    logic             accept;
    logic             out_free;
    logic             fire;
    logic             pulse;
    logic [SEG_W-1:0] seg_find;
    logic [MV_W-1:0]  gap_wide;
    logic [DEN_W-1:0] gap;
    logic [PCT_W-1:0] seg_tens;

    bgel_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign sample_stall = (state_reg != ST_IDLE);
    assign accept       = sample_valid && !sample_stall;
    assign cfg_ready    = (state_reg == ST_IDLE);
    assign out_free     = !res_valid_reg || !result_stall;
    assign fire         = (state_reg == ST_FINISH) && out_free;

    always_comb
    begin
        seg_find = SEG_W'(10);
        for (int i = 9; i >= 1; i--)
        begin
            if (mv_reg < MV_TABLE[i])
            begin
                seg_find = SEG_W'(i);
            end
        end
    end

    assign gap_wide = MV_TABLE[seg_find] - mv_reg;
    assign gap      = gap_wide[DEN_W-1:0];
    assign seg_tens = {seg_reg, 3'b000} + {2'b00, seg_reg, 1'b0};

    assign div_req.start = (state_reg == ST_SETUP) && (req_reg == REQ_SAMPLE)
                           && (mv_reg >= MV_TABLE[0]) && (mv_reg < MV_TABLE[10]);
    assign div_req.num   = {gap, 3'b000} + {2'b00, gap, 1'b0};
    assign div_req.den   = seg_span(seg_find);

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        req_next   = req_reg;
        mv_next    = mv_reg;
        seg_next   = seg_reg;
        pct_next   = pct_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    req_next   = sample_data.req_type;
                    mv_next    = sample_data.battery_mv;
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                seg_next = seg_find;
                if (mv_reg < MV_TABLE[0])
                begin
                    pct_next = '0;
                end
                else
                begin
                    pct_next = PCT_MAX;
                end
                state_next = div_req.start ? ST_DIV : ST_FINISH;
            end
            ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    pct_next   = seg_tens - {{(PCT_W-QUOT_W){1'b0}}, div_rsp.quot};
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        thr_next    = thr_reg;
        limit_next  = limit_reg;
        long_next   = long_reg;
        period_next = period_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_LOW_PCT:    thr_next    = cfg_data[PCT_W-1:0];
                CFG_LOW_LIMIT:  limit_next  = cfg_data[CNT_W-1:0];
                CFG_LONG_PRESS: long_next   = cfg_data;
                CFG_OPEN_PER:   period_next = cfg_data;
                default:        thr_next    = thr_reg;
            endcase
        end
    end

    // gauge and latch update
    always_comb
    begin
        logic [CNT_W:0]  cnt_inc;
        logic [MS_W-1:0] hold_inc;
        logic [MS_W-1:0] open_inc;
        logic            entered;

        cnt_inc    = '0;
        hold_inc   = hold_reg;
        open_inc   = open_reg;
        entered    = 1'b0;
        pulse      = 1'b0;
        last_next  = last_reg;
        low_next   = low_reg;
        emerg_next = emerg_reg;
        held_next  = held_reg;
        done_next  = done_reg;
        hold_next  = hold_reg;
        open_next  = open_reg;
        if (fire)
        begin
            unique case (req_reg)
                REQ_SAMPLE:
                begin
                    last_next = pct_reg;
                    if (pct_reg < thr_reg)
                    begin
                        cnt_inc = {1'b0, low_reg} + 1'b1;
                        if (cnt_inc > {1'b0, limit_reg})
                        begin
                            low_next = limit_reg;
                        end
                        else
                        begin
                            low_next = cnt_inc[CNT_W-1:0];
                        end
                        if ((low_next >= limit_reg) && !emerg_reg)
                        begin
                            emerg_next = 1'b1;
                            open_next  = '0;
                            pulse      = 1'b1;
                        end
                    end
                    else
                    begin
                        low_next = '0;
                    end
                end
                REQ_PRESS:
                begin
                    held_next = 1'b1;
                    hold_next = '0;
                    done_next = 1'b0;
                end
                REQ_RELEASE:
                begin
                    held_next = 1'b0;
                end
                REQ_TICK:
                begin
                    if (held_reg && !done_reg)
                    begin
                        if (hold_reg < ELAPSED_MAX)
                        begin
                            hold_inc = hold_reg + 1'b1;
                        end
                        hold_next = hold_inc;
                        if (hold_inc >= long_reg)
                        begin
                            done_next = 1'b1;
                            if (!emerg_reg)
                            begin
                                entered    = 1'b1;
                                emerg_next = 1'b1;
                                open_next  = '0;
                            end
                        end
                    end
                    if (entered)
                    begin
                        pulse = 1'b1;
                    end
                    else if (emerg_reg)
                    begin
                        if (open_reg < ELAPSED_MAX)
                        begin
                            open_inc = open_reg + 1'b1;
                        end
                        if (open_inc >= period_reg)
                        begin
                            open_next = '0;
                            pulse     = 1'b1;
                        end
                        else
                        begin
                            open_next = open_inc;
                        end
                    end
                end
                default:
                begin
                    held_next = held_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        res_data_next  = res_data_reg;
        if (fire)
        begin
            res_valid_next                = 1'b1;
            res_data_next.battery_percent = last_next;
            res_data_next.low_count       = low_next;
            res_data_next.emergency       = emerg_next;
            res_data_next.open_pulse      = pulse;
        end
        else if (!result_stall)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            thr_reg       <= 7'd20;
            limit_reg     <= 4'd3;
            long_reg      <= 17'd60000;
            period_reg    <= 17'd10000;
            last_reg      <= '0;
            low_reg       <= '0;
            emerg_reg     <= 1'b0;
            held_reg      <= 1'b0;
            done_reg      <= 1'b0;
            hold_reg      <= '0;
            open_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            thr_reg       <= thr_next;
            limit_reg     <= limit_next;
            long_reg      <= long_next;
            period_reg    <= period_next;
            last_reg      <= last_next;
            low_reg       <= low_next;
            emerg_reg     <= emerg_next;
            held_reg      <= held_next;
            done_reg      <= done_next;
            hold_reg      <= hold_next;
            open_reg      <= open_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        mv_reg       <= mv_next;
        seg_reg      <= seg_next;
        pct_reg      <= pct_next;
        res_data_reg <= res_data_next;
    end

    assign result_valid = res_valid_reg;
    assign result_data  = res_data_reg;

    `BGEL_ASSERT_NXT(a_latch_holds, clk, rst_n, emerg_reg, emerg_reg)
    `BGEL_ASSERT_IMP(a_pulse_needs_latch, clk, rst_n, res_valid_reg, !res_data_reg.open_pulse || res_data_reg.emergency)
    `BGEL_ASSERT_IMP(a_div_done_in_div, clk, rst_n, div_rsp.done, state_reg == ST_DIV)
    `BGEL_ASSERT_IMP(a_pct_in_range, clk, rst_n, state_reg == ST_FINISH, pct_reg <= PCT_MAX)

endmodule

FILE: tb/sv/tb_battery_gauge_emergency_latch.sv
`timescale 1ns / 1ps

module tb_battery_gauge_emergency_latch;
    import bgel_pkg::*;

    localparam int SETTLE_CYCLES = 16;
    localparam logic [MS_W-1:0] HOLD_SAT = {MS_W{1'b1}};
    localparam int MV_POINTS [11] = '{
        3000, 3650, 3700, 3740, 3760, 3795, 3840, 3910, 3980, 4070, 4200
    };

    typedef struct packed {
        logic [PCT_W-1:0] threshold;
        logic [CNT_W-1:0] limit;
        logic [MS_W-1:0]  press_ms;
        logic [MS_W-1:0]  period_ms;
    } gauge_cfg_t;

    typedef struct packed {
        logic [PCT_W-1:0] percent;
        logic [CNT_W-1:0] low_cnt;
        logic             latched;
        logic             held;
        logic             press_done;
        logic [MS_W-1:0]  hold_ms;
        logic [MS_W-1:0]  open_ms;
    } gauge_state_t;

    logic            clk = 1'b0;
    logic            rst_n = 1'b0;
    logic            sample_valid = 1'b0;
    logic            sample_stall;
    in_beat_t        sample_data = '0;
    logic            result_valid;
    logic            result_stall = 1'b0;
    out_beat_t       result_data;
    logic            cfg_valid = 1'b0;
    logic            cfg_ready;
    logic [1:0]      cfg_index = '0;
    logic [MS_W-1:0] cfg_data = '0;

    gauge_cfg_t   gauge_cfg;
    gauge_state_t gauge_st;
    out_beat_t    gauge_expect_q [$];
    out_beat_t    gauge_want;
    int           send_idle_pct = 0;
    int           recv_stall_pct = 0;
    int           mismatches = 0;

    battery_gauge_emergency_latch DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample_data  (sample_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic logic [PCT_W-1:0] gauge_percent(input logic [MV_W-1:0] mv);
        int k;
        int span;
        int gap;
        if (mv < MV_POINTS[0])
            return '0;
        for (k = 1; k < 11; k++)
        begin
            if (mv < MV_POINTS[k])
            begin
                span = MV_POINTS[k] - MV_POINTS[k-1];
                gap = MV_POINTS[k] - int'(mv);
                return PCT_W'(k * 10 - (10 * gap) / span);
            end
        end
        return PCT_W'(100);
    endfunction

    function automatic logic gauge_latch(inout gauge_state_t s);
        if (s.latched)
            return 1'b0;
        s.latched = 1'b1;
        s.open_ms = '0;
        return 1'b1;
    endfunction

    function automatic out_beat_t gauge_step(inout gauge_state_t s, input gauge_cfg_t c,
                                             input in_beat_t b);
        out_beat_t r;
        logic      pulse;
        logic      entered;
        int        next_cnt;
        pulse = 1'b0;
        entered = 1'b0;
        case (b.req_type)
            REQ_SAMPLE:
            begin
                s.percent = gauge_percent(b.battery_mv);
                if (s.percent < c.threshold)
                begin
                    next_cnt = s.low_cnt + 1;
                    if (next_cnt > c.limit)
                        next_cnt = int'(c.limit);
                    s.low_cnt = CNT_W'(next_cnt);
                    if (s.low_cnt >= c.limit)
                        pulse = gauge_latch(s);
                end
                else
                    s.low_cnt = '0;
            end
            REQ_PRESS:
            begin
                s.held = 1'b1;
                s.hold_ms = '0;
                s.press_done = 1'b0;
            end
            REQ_RELEASE:
                s.held = 1'b0;
            default:
            begin
                if (s.held && !s.press_done)
                begin
                    if (s.hold_ms < HOLD_SAT)
                        s.hold_ms = s.hold_ms + 1'b1;
                    if (s.hold_ms >= c.press_ms)
                    begin
                        s.press_done = 1'b1;
                        entered = gauge_latch(s);
                    end
                end
                if (entered)
                    pulse = 1'b1;
                else if (s.latched)
                begin
                    if (s.open_ms < HOLD_SAT)
                        s.open_ms = s.open_ms + 1'b1;
                    if (s.open_ms >= c.period_ms)
                    begin
                        s.open_ms = '0;
                        pulse = 1'b1;
                    end
                end
            end
        endcase
        r.battery_percent = s.percent;
        r.low_count = s.low_cnt;
        r.emergency = s.latched;
        r.open_pulse = pulse;
        return r;
    endfunction

    function automatic in_beat_t make_beat(input logic [1:0] req, input int mv);
        in_beat_t b;
        b.req_type = req;
        b.battery_mv = MV_W'(mv);
        return b;
    endfunction

    // Swap any beat whose result would show emergency latched for a release.
    function automatic in_beat_t keep_unlatched(input in_beat_t b);
        gauge_state_t trial;
        out_beat_t    r;
        trial = gauge_st;
        r = gauge_step(trial, gauge_cfg, b);
        if (r.emergency)
            b.req_type = REQ_RELEASE;
        return b;
    endfunction

    function automatic in_beat_t random_beat();
        in_beat_t b;
        int       r;
        int       m;
        r = $urandom_range(99);
        m = $urandom_range(9);
        if (m < 7)
            b.battery_mv = MV_W'($urandom_range(4300, 2900));
        else if (m < 8)
            b.battery_mv = MV_W'($urandom_range(2999, 0));
        else
            b.battery_mv = MV_W'($urandom);
        if (gauge_st.held)
            b.req_type = (r < 55) ? REQ_TICK : (r < 65) ? REQ_RELEASE :
                         (r < 70) ? REQ_PRESS : REQ_SAMPLE;
        else
            b.req_type = (r < 25) ? REQ_PRESS : (r < 45) ? REQ_TICK :
                         (r < 55) ? REQ_RELEASE : REQ_SAMPLE;
        return b;
    endfunction

    always @(posedge clk)
    begin
        if (!rst_n)
            result_stall <= 1'b0;
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (gauge_expect_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result beat %h", result_data);
                end
                else
                begin
                    gauge_want = gauge_expect_q.pop_front();
                    if (result_data.battery_percent !== gauge_want.battery_percent ||
                        result_data.low_count !== gauge_want.low_count ||
                        result_data.emergency !== gauge_want.emergency ||
                        result_data.open_pulse !== gauge_want.open_pulse)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp %0d/%0d/%0b/%0b got %0d/%0d/%0b/%0b",
                                     gauge_want.battery_percent, gauge_want.low_count,
                                     gauge_want.emergency, gauge_want.open_pulse,
                                     result_data.battery_percent, result_data.low_count,
                                     result_data.emergency, result_data.open_pulse);
                    end
                end
            end
            result_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    task automatic send_beat(input in_beat_t b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            sample_valid <= 1'b0;
            @(posedge clk);
        end
        sample_valid <= 1'b1;
        sample_data <= b;
        @(posedge clk);
        while (sample_stall)
            @(posedge clk);
        gauge_expect_q.push_back(gauge_step(gauge_st, gauge_cfg, b));
    endtask

    task automatic drain_results(input int extra);
        sample_valid <= 1'b0;
        @(posedge clk);
        while (gauge_expect_q.size() != 0)
            @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [MS_W-1:0] value);
        logic [MS_W-1:0] word;
        drain_results(SETTLE_CYCLES);
        word = value;
        // junk in the unused upper bits of narrow registers
        if (idx == CFG_LOW_PCT)
            word[MS_W-1:PCT_W] = (MS_W-PCT_W)'($urandom);
        else if (idx == CFG_LOW_LIMIT)
            word[MS_W-1:CNT_W] = (MS_W-CNT_W)'($urandom);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= word;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_LOW_PCT:    gauge_cfg.threshold = word[PCT_W-1:0];
            CFG_LOW_LIMIT:  gauge_cfg.limit = word[CNT_W-1:0];
            CFG_LONG_PRESS: gauge_cfg.press_ms = word;
            CFG_OPEN_PER:   gauge_cfg.period_ms = word;
            default: ;
        endcase
    endtask

    task automatic set_cfg(input int thr, input int lim, input int press, input int period);
        cfg_write(CFG_LOW_PCT, MS_W'(thr));
        cfg_write(CFG_LOW_LIMIT, MS_W'(lim));
        cfg_write(CFG_LONG_PRESS, MS_W'(press));
        cfg_write(CFG_OPEN_PER, MS_W'(period));
    endtask

    task automatic set_phase(input int ph);
        case (ph)
            1:       begin send_idle_pct = 72; recv_stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  recv_stall_pct = 72; end
            3:       begin send_idle_pct = 31; recv_stall_pct = 31; end
            default: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        endcase
    endtask

    task automatic run_random(input int n, input bit guard);
        in_beat_t b;
        for (int ph = 0; ph < 4; ph++)
        begin
            set_phase(ph);
            repeat (n / 4)
            begin
                b = random_beat();
                if (guard)
                    b = keep_unlatched(b);
                send_beat(b);
            end
        end
        set_phase(0);
    endtask

    task automatic test_gauge_points();
        int mvs [21] = '{0, 16383, 2999, 4200, 3000, 4199, 3001, 3700, 3649, 3740, 3650,
                         3739, 3760, 3794, 3795, 3840, 3910, 3980, 4069, 4070, 8191};
        foreach (mvs[i])
            send_beat(keep_unlatched(make_beat(REQ_SAMPLE, mvs[i])));
    endtask

    task automatic test_button_timing();
        logic [1:0] seq [18] = '{REQ_PRESS, REQ_TICK, REQ_TICK, REQ_TICK, REQ_PRESS,
                                 REQ_TICK, REQ_TICK, REQ_TICK, REQ_RELEASE, REQ_TICK,
                                 REQ_TICK, REQ_TICK, REQ_PRESS, REQ_TICK, REQ_RELEASE,
                                 REQ_RELEASE, REQ_TICK, REQ_PRESS};
        set_cfg(0, 15, 4, 1);
        foreach (seq[i])
            send_beat(keep_unlatched(make_beat(seq[i], $urandom_range(16383))));
        send_beat(make_beat(REQ_RELEASE, 0));
    endtask

    task automatic test_unlatched_random();
        set_cfg(50, 15, 40, 3);
        run_random(120, 1'b1);
        set_cfg(127, 15, 25, 131071);
        run_random(80, 1'b1);
        set_cfg(0, 1, 100000, 100000);
        run_random(80, 1'b1);
        set_cfg(100, 8, 1, 1);
        run_random(60, 1'b1);
    endtask

    // Latch through a zero-length long press, then watch the open period.
    task automatic test_long_press_entry();
        set_cfg(20, 3, 0, 5);
        send_beat(make_beat(REQ_PRESS, 0));
        send_beat(make_beat(REQ_TICK, 0));
        repeat (11) send_beat(make_beat(REQ_TICK, 16383));
        send_beat(make_beat(REQ_RELEASE, 0));
        send_beat(make_beat(REQ_TICK, 0));
    endtask

    task automatic test_latched_counts();
        set_cfg(50, 15, 131071, 131071);
        repeat (10) send_beat(make_beat(REQ_SAMPLE, 3000));
        cfg_write(CFG_LOW_LIMIT, MS_W'(4));
        send_beat(make_beat(REQ_SAMPLE, 3000));
        cfg_write(CFG_LOW_LIMIT, MS_W'(0));
        send_beat(make_beat(REQ_SAMPLE, 3000));
        send_beat(make_beat(REQ_SAMPLE, 4200));
        cfg_write(CFG_OPEN_PER, MS_W'(0));
        repeat (3) send_beat(make_beat(REQ_TICK, 0));
        cfg_write(CFG_OPEN_PER, MS_W'(1));
        repeat (3) send_beat(make_beat(REQ_TICK, 0));
        cfg_write(CFG_OPEN_PER, MS_W'(131071));
        cfg_write(CFG_LONG_PRESS, MS_W'(0));
        send_beat(make_beat(REQ_PRESS, 0));
        send_beat(make_beat(REQ_TICK, 0));
        send_beat(make_beat(REQ_TICK, 0));
        send_beat(make_beat(REQ_RELEASE, 0));
    endtask

    task automatic test_pause_resume();
        set_cfg(40, 6, 10, 4);
        set_phase(1);
        repeat (30) send_beat(random_beat());
        drain_results(0);
        repeat (30) send_beat(random_beat());
        set_phase(0);
    endtask

    task automatic test_latched_random();
        set_cfg(0, 0, 1, 2);
        run_random(100, 1'b0);
        set_cfg(127, 15, 100000, 7);
        run_random(100, 1'b0);
        set_cfg(100, 1, 3, 0);
        run_random(100, 1'b0);
        set_cfg(64, 9, 131071, 100000);
        run_random(100, 1'b0);
    endtask

    initial
    begin
        gauge_cfg.threshold = 7'd20;
        gauge_cfg.limit = 4'd3;
        gauge_cfg.press_ms = 17'd60000;
        gauge_cfg.period_ms = 17'd10000;
        gauge_st = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        test_gauge_points();
        test_button_timing();
        test_unlatched_random();
        test_long_press_entry();
        test_latched_counts();
        test_pause_resume();
        test_latched_random();
        drain_results(SETTLE_CYCLES);
        if (mismatches == 0)
            $display("battery_gauge_emergency_latch regression: pass");
        else
            $display("battery_gauge_emergency_latch regression: fail");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("battery_gauge_emergency_latch regression: fail");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+sv
sv/bgel_pkg.sv
sv/bgel_div.sv
sv/battery_gauge_emergency_latch.sv
tb/sv/tb_battery_gauge_emergency_latch.sv
